/* rtl/core/ole_pkg.sv */
// Package for the ordered list engine: operation and status codes,
// the controller state type and the controller-to-datapath command struct.
// No dependencies.
package ole_pkg;

   localparam int DataWidth   = 32;
   localparam int PosWidth    = 5;
   localparam int CountWidth  = 5;
   localparam int ReqBits     = 48;
   localparam int RspBits     = 48;

   typedef enum logic [3:0] {
      OP_INS_FRONT = 4'd0,
      OP_INS_BACK  = 4'd1,
      OP_INS_POS   = 4'd2,
      OP_DEL_FRONT = 4'd3,
      OP_DEL_BACK  = 4'd4,
      OP_DEL_VALUE = 4'd5,
      OP_RD_FRONT  = 4'd6,
      OP_RD_BACK   = 4'd7,
      OP_RD_POS    = 4'd8
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_FULL     = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_EXEC = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic load;    // latch the accepted item and its match vector
      logic commit;  // apply the operation and load the result register
   } ctl_cmd_type;

endpackage

/* rtl/core/ordered_list_engine_unit.sv */
// Ordered list engine: a bounded list of signed 32-bit values kept in a
// shifting cell chain. Instantiates ole_ctrl and ole_datapath; uses ole_pkg.
//
// Usage:
//   Each item on the req_ stream carries one operation (insert front, back
//   or at a 1-based position; remove front, back or by value; read front,
//   back or at a position). Every item produces exactly one item on the
//   rsp_ stream with the value read or removed, a status code, the found
//   flag of a remove by value and the entry count after the operation.
//   Each item is handled in order: the accept cycle registers the item and a
//   compare of every cell against its value, then the execute state updates
//   the chain and loads the result register. No new item is taken until the
//   previous one has been committed to the result register.
//   While a result waits on rsp_tready the next item is still accepted;
//   it is then held before its update until the result register is free.
//   Reset empties the list; cell contents are not cleared and are only
//   ever read below the entry count.
module ordered_list_engine_unit #(
   parameter int CAPACITY = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // opcode[3:0], data_value[35:4], position[40:36], zero pad[47:41]
   input  logic [ole_pkg::ReqBits-1:0]    req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // read_value[31:0], status[34:32], found[35], entry_count[40:36], zero[47:41]
   output logic [ole_pkg::RspBits-1:0]    rsp_tdata
);
   import ole_pkg::*;

   ctl_cmd_type          cmd;
   logic signed [31:0]   read_value;
   logic [2:0]           status;
   logic                 found;
   logic [4:0]           entry_count;

   ole_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ole_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .in_opcode     (req_tdata[3:0]),
      .in_data_value (req_tdata[35:4]),
      .in_position   (req_tdata[40:36]),
      .read_value    (read_value),
      .status        (status),
      .found         (found),
      .entry_count   (entry_count)
   );

   assign rsp_tdata = {7'd0, entry_count, found, status, read_value};

endmodule

/* rtl/core/ole_datapath.sv */
// Datapath of the ordered list engine: shifting cell chain, occupancy,
// per-cell match vector and the result register. Uses ole_pkg.
module ole_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ole_pkg::ctl_cmd_type          cmd,
   input  logic [3:0]                    in_opcode,
   input  logic signed [31:0]            in_data_value,
   input  logic [4:0]                    in_position,
   output logic signed [31:0]            read_value,
   output logic [2:0]                    status,
   output logic                          found,
   output logic [4:0]                    entry_count
);
   import ole_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int ZW = (CW > PosWidth) ? CW : PosWidth;

   logic signed [DataWidth-1:0] cells_ff [CAPACITY];
   logic signed [DataWidth-1:0] cells_in [CAPACITY];
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [CAPACITY-1:0]         match_ff;
   logic [3:0]                  op_ff;
   logic signed [DataWidth-1:0] val_ff;
   logic [PosWidth-1:0]         pos_ff;

   logic signed [DataWidth-1:0] rv_ff, rv_in;
   logic [2:0]                  st_ff, st_in;
   logic                        fnd_ff, fnd_in;
   logic [CountWidth-1:0]       ec_ff;

   logic [ZW-1:0]               pos_z, cnt_z;
   logic                        full, empty;
   logic [IW-1:0]               back_idx, ins_idx, rm_idx, rd_idx, hit_idx;
   logic                        ins_en, rm_en, hit_any;
   logic [CAPACITY-1:0]         live_match;

   assign pos_z    = ZW'(pos_ff);
   assign cnt_z    = ZW'(cnt_ff);
   assign full     = (cnt_ff == CW'(CAPACITY));
   assign empty    = (cnt_ff == '0);
   assign back_idx = IW'(cnt_ff - CW'(1));

   // Remove by value: front first, then back, then the earliest middle entry.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         live_match[i] = match_ff[i] && (CW'(i) < cnt_ff);
      end
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (live_match[i]) begin
            hit_any = 1'b1;
            hit_idx = IW'(i);
         end
      end
      if (live_match[0]) begin
         hit_idx = '0;
      end else if (live_match[back_idx]) begin
         hit_idx = back_idx;
      end
   end

   always_comb begin
      ins_en = 1'b0;
      rm_en  = 1'b0;
      ins_idx = '0;
      rm_idx  = '0;
      rd_idx  = '0;
      rv_in   = '0;
      st_in   = ST_OK;
      fnd_in  = 1'b0;
      cnt_in  = cnt_ff;
      case (op_ff)
         OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
            if (full) begin
               st_in = ST_FULL;
            end else if (op_ff == OP_INS_FRONT) begin
               ins_en = 1'b1;
            end else if (op_ff == OP_INS_BACK) begin
               ins_en = 1'b1;
               ins_idx = IW'(cnt_ff);
            end else if (empty || pos_z == ZW'(1)) begin
               ins_en = 1'b1;
            end else if (pos_z > cnt_z) begin
               ins_en = 1'b1;
               ins_idx = IW'(cnt_ff);
            end else if (pos_z == '0) begin
               st_in = ST_BADPOS;
            end else begin
               ins_en = 1'b1;
               ins_idx = IW'(pos_z - ZW'(1));
            end
         end
         OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_VALUE,
         OP_RD_FRONT, OP_RD_BACK, OP_RD_POS: begin
            if (empty) begin
               st_in = ST_EMPTY;
            end else begin
               case (op_ff)
                  OP_DEL_FRONT: begin
                     rm_en = 1'b1;
                     rd_idx = '0;
                  end
                  OP_DEL_BACK: begin
                     rm_en = 1'b1;
                     rm_idx = back_idx;
                     rd_idx = back_idx;
                  end
                  OP_DEL_VALUE: begin
                     if (hit_any) begin
                        rm_en  = 1'b1;
                        rm_idx = hit_idx;
                        rd_idx = hit_idx;
                        fnd_in = 1'b1;
                     end else begin
                        st_in = ST_NOTFOUND;
                     end
                  end
                  OP_RD_FRONT: rd_idx = '0;
                  OP_RD_BACK:  rd_idx = back_idx;
                  default: begin
                     if (pos_z <= ZW'(1)) begin
                        rd_idx = '0;
                     end else if (pos_z >= cnt_z) begin
                        rd_idx = back_idx;
                     end else begin
                        rd_idx = IW'(pos_z - ZW'(1));
                     end
                  end
               endcase
               if (st_in == ST_OK) begin
                  rv_in = cells_ff[rd_idx];
               end
            end
         end
         default: begin
         end
      endcase
      if (ins_en) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (rm_en) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   // Shift the chain open at an insert, closed at a removal.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
         if (ins_en) begin
            if (IW'(i) == ins_idx) begin
               cells_in[i] = val_ff;
            end else if (i > 0 && IW'(i) > ins_idx) begin
               cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (rm_en) begin
            if (i < CAPACITY - 1 && IW'(i) >= rm_idx) begin
               cells_in[i] = cells_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.commit) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= in_opcode;
         val_ff <= in_data_value;
         pos_ff <= in_position;
         for (int i = 0; i < CAPACITY; i++) begin
            match_ff[i] <= (cells_ff[i] == in_data_value);
         end
      end
      if (cmd.commit) begin
         for (int i = 0; i < CAPACITY; i++) begin
            cells_ff[i] <= cells_in[i];
         end
         rv_ff  <= rv_in;
         st_ff  <= st_in;
         fnd_ff <= fnd_in;
         ec_ff  <= CountWidth'(cnt_in);
      end
   end

   assign read_value  = rv_ff;
   assign status      = st_ff;
   assign found       = fnd_ff;
   assign entry_count = ec_ff;

endmodule

/* rtl/core/ole_ctrl.sv */
// Controller of the ordered list engine: two-state sequencer and the
// result valid flag. Uses ole_pkg.
module ole_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output ole_pkg::ctl_cmd_type cmd
);
   import ole_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.commit   = 1'b0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         CTL_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = CTL_IDLE;
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
